### rtl/fsmatch_pkg.sv
// Shared types and codes for the first substring match block.
package fsmatch_pkg;

  localparam logic KIND_PATTERN = 1'b0;
  localparam logic KIND_TEXT    = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_byte;
    logic       last;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [15:0] match_index;
    logic        index_overflow;
    logic        pattern_overflow;
  } rsp_t;

  typedef struct packed {
    logic       load;
    logic       shift;
    logic       clear;
    logic [7:0] char_byte;
  } cell_ctrl_t;

endpackage

### rtl/fsmatch_cell.sv
// One pattern cell: holds a pattern byte and the partial-match flag for its prefix.
module fsmatch_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  fsmatch_pkg::cell_ctrl_t ctrl,
  input  logic                    sel,
  input  logic                    prev_match,
  output logic                    match_next,
  output logic                    match
);
  import fsmatch_pkg::*;

  logic [7:0] pat;

  assign match_next = prev_match && (ctrl.char_byte == pat);

  always_ff @(posedge clk) begin
    if (ctrl.load && sel) begin
      pat <= ctrl.char_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      match <= 1'b0;
    end else if (ctrl.shift) begin
      match <= match_next;
    end
  end

endmodule

### rtl/first_substring_match.sv
// Top level: request decode, pattern length and text position tracking, cell row, result register.
//
//   channel | valid     | stall     | payload
//   request | req_valid | req_stall | req (kind, char_byte, last)
//   result  | rsp_valid | rsp_stall | rsp (found, match_index, index_overflow, pattern_overflow)
//
// One request per cycle unless req_stall is high; the result of a last text byte is registered.
// Each text byte is broadcast to all cells, each cell extends its neighbor's prefix flag.
// Reset clears pattern length, flags and position; pattern bytes are kept in the cells.
// A result that meets a stalled one waits in a skid register; req_stall is that
// register's valid, so it has no path from rsp_stall.
module first_substring_match #(
  parameter int              PATTERN_MAX = 16,
  parameter longint unsigned TEXT_MAX    = 65535
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  fsmatch_pkg::req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output fsmatch_pkg::rsp_t rsp
);
  import fsmatch_pkg::*;

  localparam longint unsigned LIMIT = (TEXT_MAX < 65535) ? TEXT_MAX : 65535;
  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int POS_W = $clog2(LIMIT + PATTERN_MAX + 2);

  logic [LEN_W-1:0] len, len_next, len_eff;
  logic             closed, closed_next;
  logic             excess, excess_next;
  logic [POS_W-1:0] pos, pos_next;
  logic             latched, latched_next;
  logic [15:0]      lidx, lidx_next;
  logic             over, over_next;

  logic             accept, pat_acc, txt_acc, start_pat, emit, hit, over_now;
  logic [POS_W-1:0] start_full;
  logic [15:0]      start_idx;
  cell_ctrl_t       ctrl;
  logic [PATTERN_MAX-1:0] sel_wr, sel_end, match_next, match, prev_match;
  rsp_t             rsp_next;
  logic             skid_valid;
  rsp_t             skid;

  assign req_stall = skid_valid;
  assign accept    = req_valid && !req_stall;
  assign pat_acc   = accept && (req.kind == KIND_PATTERN);
  assign txt_acc   = accept && (req.kind == KIND_TEXT);
  assign start_pat = pat_acc && closed;
  assign emit      = txt_acc && req.last;
  assign len_eff   = start_pat ? '0 : len;

  always_comb begin
    ctrl.load      = pat_acc && (len_eff < LEN_W'(PATTERN_MAX));
    ctrl.shift     = txt_acc;
    ctrl.clear     = start_pat || emit;
    ctrl.char_byte = req.char_byte;
  end

  genvar j;
  generate
    for (j = 0; j < PATTERN_MAX; j++) begin : g_cell
      assign sel_wr[j]  = (len_eff == LEN_W'(j));
      assign sel_end[j] = (len == LEN_W'(j + 1));
      if (j == 0) begin : g_head
        assign prev_match[j] = 1'b1;
      end else begin : g_link
        assign prev_match[j] = match[j-1];
      end
      fsmatch_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .sel        (sel_wr[j]),
        .prev_match (prev_match[j]),
        .match_next (match_next[j]),
        .match      (match[j])
      );
    end
  endgenerate

  always_comb begin
    hit        = !latched && |(match_next & sel_end);
    over_now   = over || (pos > POS_W'(LIMIT));
    start_full = pos + POS_W'(1) - POS_W'(len);
    start_idx  = (start_full > POS_W'(LIMIT)) ? 16'(LIMIT) : start_full[15:0];
  end

  always_comb begin
    len_next    = len;
    excess_next = excess;
    closed_next = closed;
    if (pat_acc) begin
      len_next    = ctrl.load ? len_eff + LEN_W'(1) : len_eff;
      excess_next = (start_pat ? 1'b0 : excess) || !ctrl.load;
      closed_next = req.last;
    end else if (txt_acc) begin
      closed_next = 1'b1;
    end
  end

  always_comb begin
    pos_next     = pos;
    latched_next = latched;
    lidx_next    = lidx;
    over_next    = over;
    if (ctrl.clear) begin
      pos_next     = '0;
      latched_next = 1'b0;
      lidx_next    = '0;
      over_next    = 1'b0;
    end else if (txt_acc) begin
      over_next = over_now;
      if (pos < POS_W'(LIMIT + PATTERN_MAX)) begin
        pos_next = pos + POS_W'(1);
      end
      if (hit) begin
        latched_next = 1'b1;
        lidx_next    = start_idx;
      end
    end
  end

  always_comb begin
    rsp_next.found            = latched || hit;
    rsp_next.match_index      = latched ? lidx : (hit ? start_idx : 16'd0);
    rsp_next.index_overflow   = over_now;
    rsp_next.pattern_overflow = excess;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      closed  <= 1'b1;
      excess  <= 1'b0;
      pos     <= '0;
      latched <= 1'b0;
      lidx    <= '0;
      over    <= 1'b0;
    end else begin
      len     <= len_next;
      closed  <= closed_next;
      excess  <= excess_next;
      pos     <= pos_next;
      latched <= latched_next;
      lidx    <= lidx_next;
      over    <= over_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!rsp_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (emit) begin
      if (rsp_valid && rsp_stall) begin
        skid_valid <= 1'b1;
      end else begin
        rsp_valid <= 1'b1;
      end
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!rsp_stall) begin
        rsp <= skid;
      end
    end else if (emit) begin
      if (rsp_valid && rsp_stall) begin
        skid <= rsp_next;
      end else begin
        rsp <= rsp_next;
      end
    end
  end

endmodule

### rtl/fsmatch_checker.sv
// Port-level checks for the first substring match block, bound to the top level.
module fsmatch_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input fsmatch_pkg::req_t req,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input fsmatch_pkg::rsp_t rsp
);
  import fsmatch_pkg::*;

  logic text_done;
  assign text_done = req_valid && !req_stall && (req.kind == KIND_TEXT) && req.last;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid)
    else $error("request stalled without a held result");

  a_text_result: assert property (@(posedge clk) disable iff (rst)
    text_done |=> rsp_valid)
    else $error("last text byte gave no result");

  a_new_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !$past(rsp_valid) |-> $past(text_done))
    else $error("result without a last text byte");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.match_index == 16'd0)
    else $error("nonzero index without a match");

endmodule

bind first_substring_match fsmatch_checker u_fsmatch_checker (.*);

### verif/first_substring_match_test.sv
// Testbench for first_substring_match: directed and random pattern/text streams checked against a built-in search predictor.
module first_substring_match_test;
  import fsmatch_pkg::*;

  localparam int              PATTERN_MAX = 16;
  localparam longint unsigned TEXT_MAX    = 65535;
  localparam int              IDX_LIMIT   = 65535;

  typedef logic [7:0] byte_q_t[$];

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_stall = 1'b0;
  req_t req       = '0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;

  first_substring_match #(
    .PATTERN_MAX(PATTERN_MAX),
    .TEXT_MAX(TEXT_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #6 clk = ~clk;

  // search predictor state
  logic [7:0]  pat_bytes [PATTERN_MAX] = '{default: 8'h00};
  logic [4:0]  pat_len    = '0;
  logic        pat_closed = 1'b1;
  logic        pat_excess = 1'b0;
  logic [7:0]  win [PATTERN_MAX] = '{default: 8'h00};
  logic [16:0] text_pos   = '0;
  logic        hit_seen   = 1'b0;
  logic [15:0] hit_index  = '0;
  logic        pos_over   = 1'b0;

  rsp_t search_outcomes[$];

  int req_pace = 0;
  int rsp_pace = 0;
  int rsp_hold_cycles = 0;
  int reqs_taken = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int bad_results = 0;
  logic [7:0] alphabet [4];

  function automatic void clear_scan();
    for (int k = 0; k < PATTERN_MAX; k++) win[k] = 8'h00;
    text_pos = '0;
    hit_seen = 1'b0;
    hit_index = '0;
    pos_over = 1'b0;
  endfunction

  function automatic void advance_search(input req_t r);
    int pos;
    int plen;
    int start;
    logic hit;
    rsp_t outcome;
    if (r.kind == KIND_PATTERN) begin
      if (pat_closed) begin
        pat_len = '0;
        pat_excess = 1'b0;
        pat_closed = 1'b0;
        clear_scan();
      end
      if (pat_len < PATTERN_MAX) begin
        pat_bytes[pat_len] = r.char_byte;
        pat_len = pat_len + 1'b1;
      end else begin
        pat_excess = 1'b1;
      end
      if (r.last) pat_closed = 1'b1;
      return;
    end
    pat_closed = 1'b1;
    for (int k = PATTERN_MAX - 1; k > 0; k--) win[k] = win[k - 1];
    win[0] = r.char_byte;
    pos = int'(text_pos);
    if (pos > IDX_LIMIT) pos_over = 1'b1;
    if (pos < IDX_LIMIT + PATTERN_MAX) text_pos = text_pos + 1'b1;
    plen = int'(pat_len);
    if (!hit_seen && plen > 0 && pos + 1 >= plen) begin
      hit = 1'b1;
      for (int j = 0; j < plen; j++)
        if (win[plen - 1 - j] != pat_bytes[j]) hit = 1'b0;
      if (hit) begin
        start = pos + 1 - plen;
        if (start > IDX_LIMIT) start = IDX_LIMIT;
        hit_seen = 1'b1;
        hit_index = start[15:0];
      end
    end
    if (!r.last) return;
    outcome.found = hit_seen;
    outcome.match_index = hit_seen ? hit_index : 16'd0;
    outcome.index_overflow = pos_over;
    outcome.pattern_overflow = pat_excess;
    search_outcomes.push_back(outcome);
    clear_scan();
  endfunction

  function automatic int draw_wait(input int pace);
    if (pace == 0) return 0;
    if (pace == 1) return $urandom_range(0, 17);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
  endfunction

  function automatic logic [7:0] pick_char(input logic wide, input int nsym);
    if (wide) return 8'($urandom);
    return alphabet[$urandom_range(0, nsym - 1)];
  endfunction

  function automatic void flag_bad(input string what, input rsp_t want);
    bad_results++;
    if (bad_results <= 10)
      $display({"%s: expected found=%0b index=%0d iovf=%0b povf=%0b, ",
                "got found=%0b index=%0d iovf=%0b povf=%0b"},
               what, want.found, want.match_index, want.index_overflow,
               want.pattern_overflow, rsp.found, rsp.match_index, rsp.index_overflow,
               rsp.pattern_overflow);
  endfunction

  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (rsp.found) hits_seen++;
      if (search_outcomes.size() == 0) begin
        flag_bad("unexpected result", '0);
      end else begin
        want = search_outcomes.pop_front();
        if (rsp.found !== want.found || rsp.match_index !== want.match_index ||
            rsp.index_overflow !== want.index_overflow ||
            rsp.pattern_overflow !== want.pattern_overflow) begin
          flag_bad("result mismatch", want);
        end
      end
    end
  end

  initial begin : rsp_side
    int wait_left;
    int held;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (rsp_hold_cycles > 0) begin
        held = rsp_hold_cycles;
        rsp_hold_cycles = 0;
        rsp_stall <= 1'b1;
        repeat (held) @(posedge clk);
        rsp_stall <= 1'b0;
        wait_left = 0;
      end else if (rsp_valid && !rsp_stall) begin
        wait_left = draw_wait(rsp_pace);
        if (wait_left > 0) rsp_stall <= 1'b1;
      end else if (rsp_valid && rsp_stall && wait_left > 0) begin
        wait_left--;
        if (wait_left == 0) rsp_stall <= 1'b0;
      end
    end
  end

  task automatic offer_req(input logic kind, input logic [7:0] ch, input logic fin);
    int gap;
    req_t r;
    gap = draw_wait(req_pace);
    r.kind = kind;
    r.char_byte = ch;
    r.last = fin;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    advance_search(r);
    reqs_taken++;
  endtask

  task automatic send_pattern(input byte_q_t bytes, input logic close);
    for (int i = 0; i < bytes.size(); i++)
      offer_req(KIND_PATTERN, bytes[i], close && i == bytes.size() - 1);
  endtask

  task automatic send_text(input byte_q_t bytes, input logic fin);
    for (int i = 0; i < bytes.size(); i++)
      offer_req(KIND_TEXT, bytes[i], fin && i == bytes.size() - 1);
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (search_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    req_pace = 2;
    rsp_pace = 2;
    send_text('{8'h41, 8'h42}, 1'b1);
    send_pattern('{8'h00}, 1'b1);
    send_text('{8'h00}, 1'b1);
    send_pattern('{8'hFF, 8'h80}, 1'b1);
    send_text('{8'h01, 8'hFF, 8'hFF, 8'h80}, 1'b1);
    send_pattern('{8'h7E, 8'h7E, 8'h7F}, 1'b1);
    send_text('{8'h7E, 8'h7E}, 1'b1);
    send_pattern('{8'h41}, 1'b0);
    send_text('{8'h41}, 1'b1);
    send_pattern('{8'h42}, 1'b1);
    send_text('{8'h42}, 1'b0);
    send_pattern('{8'h43}, 1'b1);
    send_text('{8'h43}, 1'b1);
    wait_for_results();
  endtask

  task automatic test_pattern_overflow();
    byte_q_t pat;
    byte_q_t txt;
    req_pace = 1;
    rsp_pace = 1;
    for (int i = 0; i < 20; i++) pat.push_back(8'($urandom));
    send_pattern(pat, 1'b1);
    for (int i = 0; i < 3; i++) txt.push_back(8'($urandom));
    for (int i = 0; i < PATTERN_MAX; i++) txt.push_back(pat[i]);
    send_text(txt, 1'b1);
    send_text('{8'h11, 8'h22, 8'h33}, 1'b1);
    send_pattern('{8'h33}, 1'b1);
    send_text('{8'h22, 8'h33}, 1'b1);
    wait_for_results();
  endtask

  task automatic test_backpressure();
    req_pace = 0;
    rsp_pace = 0;
    send_pattern('{8'h5C}, 1'b1);
    rsp_hold_cycles = 300;
    for (int i = 0; i < 40; i++)
      offer_req(KIND_TEXT, (i % 3 == 0) ? 8'h5C : 8'($urandom), 1'b1);
    wait_for_results();
  endtask

  task automatic test_random(input int budget);
    byte_q_t pat;
    byte_q_t txt;
    int nsym;
    int plen;
    int ntext;
    int first;
    logic wide;
    first = reqs_taken;
    while (reqs_taken - first < budget) begin
      req_pace = $urandom_range(0, 2);
      rsp_pace = $urandom_range(0, 2);
      nsym = $urandom_range(1, 4);
      for (int i = 0; i < 4; i++) alphabet[i] = 8'($urandom);
      wide = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) != 0) begin
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 5);
        pat = {};
        for (int i = 0; i < plen; i++) pat.push_back(pick_char(wide, nsym));
        send_pattern(pat, $urandom_range(0, 9) != 0);
      end
      ntext = $urandom_range(1, 3);
      for (int t = 0; t < ntext; t++) begin
        txt = {};
        repeat ($urandom_range(0, 20)) txt.push_back(pick_char(wide, nsym));
        if (pat.size() > 0 && $urandom_range(0, 1) == 1)
          for (int i = 0; i < pat.size() && i < PATTERN_MAX; i++) txt.push_back(pat[i]);
        repeat ($urandom_range(0, 8)) txt.push_back(pick_char(wide, nsym));
        if (txt.size() == 0) txt.push_back(pick_char(wide, nsym));
        send_text(txt, $urandom_range(0, 11) != 0);
      end
    end
    wait_for_results();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_pattern_overflow();
    test_backpressure();
    test_random(1320);
    repeat (8) @(posedge clk);
    $display("ran %0d requests: directed, oversized pattern, held output, random mixes",
             reqs_taken);
    $display("%0d results, %0d with a match; %0d bad, %0d never delivered",
             results_seen, hits_seen, bad_results, search_outcomes.size());
    if (bad_results == 0 && search_outcomes.size() == 0) begin
      $display("first_substring_match test passed");
    end else begin
      $display("first_substring_match test failed");
    end
    $finish;
  end

  initial begin
    #(12 * 2000000);
    $display("timeout waiting on the block");
    $display("first_substring_match test failed");
    $finish;
  end

endmodule
